@@ hw/rtl/m44_pkg.sv @@
// ----------------------------------------------------------------------------
// m44_pkg
// Shared types, constants and binary32 arithmetic steps for the 4x4 matrix
// multiply unit.
// ----------------------------------------------------------------------------
package m44_pkg;

  localparam int DIM    = 4;
  localparam int FP_W   = 32;
  localparam int IN_W   = 264;
  localparam int OUT_W  = 136;

  localparam logic [FP_W-1:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [7:0]      EXP_MAX   = 8'hFF;

  // Controller commands to the datapath
  typedef struct packed {
    logic       store;
    logic       mul_a;
    logic       mul_b;
    logic       add_a;
    logic       add_b;
    logic       first_k;
    logic       out_load;
    logic [1:0] i;
    logic [1:0] k;
  } m44_cmd_t;

  // Multiplier first-stage result
  typedef struct packed {
    logic              nan;
    logic              inf;
    logic              zero;
    logic              sgn;
    logic signed [11:0] etop;
    logic [47:0]       prod;
  } mul_st_t;

  // Adder first-stage result
  typedef struct packed {
    logic              nan;
    logic              inf;
    logic              zero;
    logic              sgn;
    logic signed [11:0] etop;
    logic [27:0]       sum;
  } add_st_t;

  // Normalize, round to nearest even and pack. mag is nonzero; a one in
  // bit 47 of mag carries biased exponent etop.
  function automatic logic [31:0] fp_round(input logic sgn,
                                           input logic signed [11:0] etop,
                                           input logic [47:0] mag);
    logic [5:0]         lz;
    logic signed [11:0] er;
    logic signed [11:0] ef;
    logic [47:0]        sn;
    logic [5:0]         rsh;
    logic               stk;
    logic [23:0]        mant;
    logic               inc;
    logic [24:0]        rnd;
    logic [31:0]        res;
    lz = '0;
    for (int b = 0; b < 48; b++) begin
      if (mag[b]) lz = 6'(47 - b);
    end
    sn  = mag << lz;
    er  = etop - $signed({6'b0, lz});
    stk = 1'b0;
    rsh = '0;
    // Denormalize into the subnormal range
    if (er < 12'sd1) begin
      if (er < -12'sd48) begin
        stk = |sn;
        sn  = '0;
      end else begin
        rsh = 6'(12'sd1 - er);
        stk = |(sn & ((48'd1 << rsh) - 48'd1));
        sn  = sn >> rsh;
      end
      er = 12'sd0;
    end
    mant = sn[47:24];
    inc  = sn[23] & (stk | (|sn[22:0]) | mant[0]);
    rnd  = {1'b0, mant} + 25'(inc);
    if (er == 12'sd0) begin
      res = {sgn, 7'b0, rnd[23], rnd[22:0]};
    end else begin
      ef = rnd[24] ? er + 12'sd1 : er;
      if (ef >= 12'sd255) begin
        res = {sgn, EXP_MAX, 23'b0};
      end else if (rnd[24]) begin
        res = {sgn, ef[7:0], 23'b0};
      end else begin
        res = {sgn, ef[7:0], rnd[22:0]};
      end
    end
    return res;
  endfunction

  // Multiply, first half: classify and form the raw significand product
  function automatic mul_st_t fp_mul_a(input logic [31:0] a, input logic [31:0] b);
    mul_st_t     r;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic        an;
    logic        bn;
    logic        ai;
    logic        bi;
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    an = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
    bn = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
    ai = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
    bi = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
    r.sgn  = a[31] ^ b[31];
    r.nan  = an | bn | (ai & (mb == 24'd0)) | (bi & (ma == 24'd0));
    r.inf  = ai | bi;
    r.zero = (ma == 24'd0) || (mb == 24'd0);
    r.etop = $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd126;
    r.prod = ma * mb;
    return r;
  endfunction

  // Multiply, second half
  function automatic logic [31:0] fp_mul_b(input mul_st_t s);
    logic [31:0] r;
    if (s.nan) r = CANON_NAN;
    else if (s.inf) r = {s.sgn, EXP_MAX, 23'b0};
    else if (s.zero) r = {s.sgn, 31'b0};
    else r = fp_round(s.sgn, s.etop, s.prod);
    return r;
  endfunction

  // Add, first half: order by magnitude, align and add or subtract
  function automatic add_st_t fp_add_a(input logic [31:0] x, input logic [31:0] y);
    add_st_t     r;
    logic [31:0] a;
    logic [31:0] b;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [7:0]  d;
    logic [26:0] ma;
    logic [26:0] mb;
    logic [26:0] mal;
    logic        an;
    logic        bn;
    logic        ai;
    logic        bi;
    logic        sub;
    if (y[30:0] > x[30:0]) begin
      a = y;
      b = x;
    end else begin
      a = x;
      b = y;
    end
    an  = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
    bn  = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
    ai  = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
    bi  = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
    sub = a[31] ^ b[31];
    ea  = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    d   = ea - eb;
    ma  = {a[30:23] != 8'd0, a[22:0], 3'b0};
    mb  = {b[30:23] != 8'd0, b[22:0], 3'b0};
    // Align the smaller operand, fold shifted-out bits into a sticky bit
    if (d >= 8'd27) begin
      mal = {26'b0, |mb};
    end else begin
      mal = (mb >> d) | {26'b0, |(mb & ((27'd1 << d) - 27'd1))};
    end
    r.nan  = an | bn | (ai & bi & sub);
    r.inf  = ai | bi;
    r.sgn  = a[31];
    r.etop = $signed({4'b0, ea}) + 12'sd1;
    r.sum  = sub ? ({1'b0, ma} - {1'b0, mal}) : ({1'b0, ma} + {1'b0, mal});
    r.zero = (r.sum == 28'd0);
    if (r.zero && sub) r.sgn = 1'b0;
    return r;
  endfunction

  // Add, second half
  function automatic logic [31:0] fp_add_b(input add_st_t s);
    logic [31:0] r;
    if (s.nan) r = CANON_NAN;
    else if (s.inf) r = {s.sgn, EXP_MAX, 23'b0};
    else if (s.zero) r = {s.sgn, 31'b0};
    else r = fp_round(s.sgn, s.etop, {s.sum, 20'b0});
    return r;
  endfunction

endpackage

@@ hw/rtl/m44_ctrl.sv @@
// ----------------------------------------------------------------------------
// m44_ctrl
// Sequencer: steps rows and k terms through the shared lanes and owns the
// stream handshakes.
// ----------------------------------------------------------------------------
module m44_ctrl import m44_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  logic     s_tlast,
  output logic     m_tvalid,
  input  logic     m_tready,
  output m44_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MULA = 6'b000010,
    ST_MULB = 6'b000100,
    ST_ADDA = 6'b001000,
    ST_ADDB = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] row;
  logic [1:0] row_next;
  logic [1:0] kk;
  logic [1:0] kk_next;
  logic       take;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign take     = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;

  // Next state and step counters
  always_comb begin
    state_next = state;
    row_next   = row;
    kk_next    = kk;
    case (state)
      ST_IDLE: begin
        if (take && s_tlast) begin
          state_next = ST_MULA;
          row_next   = 2'd0;
          kk_next    = 2'd0;
        end
      end
      ST_MULA: state_next = ST_MULB;
      ST_MULB: state_next = ST_ADDA;
      ST_ADDA: state_next = ST_ADDB;
      ST_ADDB: begin
        if (kk == 2'(DIM - 1)) begin
          state_next = ST_EMIT;
        end else begin
          kk_next    = kk + 2'd1;
          state_next = ST_MULA;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          kk_next = 2'd0;
          if (row == 2'(DIM - 1)) begin
            state_next = ST_IDLE;
          end else begin
            row_next   = row + 2'd1;
            state_next = ST_MULA;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd.store    = take;
    cmd.mul_a    = (state == ST_MULA);
    cmd.mul_b    = (state == ST_MULB);
    cmd.add_a    = (state == ST_ADDA);
    cmd.add_b    = (state == ST_ADDB);
    cmd.first_k  = (kk == 2'd0);
    cmd.out_load = (state == ST_EMIT) && out_free;
    cmd.i        = row;
    cmd.k        = kk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      row      <= 2'd0;
      kk       <= 2'd0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      row   <= row_next;
      kk    <= kk_next;
      // Hold the result until the transfer completes
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/m44_datapath.sv @@
// ----------------------------------------------------------------------------
// m44_datapath
// Operand stores, four multiply/add lanes (one per product column),
// accumulators and the output register.
// ----------------------------------------------------------------------------
module m44_datapath import m44_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  m44_cmd_t         cmd,
  input  logic [IN_W-1:0]  s_tdata,
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tlast
);

  logic [FP_W-1:0] lmat [DIM][DIM];
  logic [FP_W-1:0] rmat [DIM][DIM];
  logic [FP_W-1:0] lop;
  mul_st_t         mst  [DIM];
  logic [FP_W-1:0] prod [DIM];
  add_st_t         ast  [DIM];
  logic [FP_W-1:0] acc  [DIM];
  logic [1:0]      wr_row;

  assign wr_row = s_tdata[1:0];
  assign lop    = lmat[cmd.i][cmd.k];

  // Store both operand rows on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          lmat[r][c] <= '0;
          rmat[r][c] <= '0;
        end
      end
    end else if (cmd.store) begin
      for (int c = 0; c < DIM; c++) begin
        lmat[wr_row][c] <= s_tdata[2 + c*FP_W +: FP_W];
        rmat[wr_row][c] <= s_tdata[2 + (DIM + c)*FP_W +: FP_W];
      end
    end
  end

  // Lanes: multiply in two steps, then add into the accumulator in two steps
  always_ff @(posedge clk) begin
    for (int j = 0; j < DIM; j++) begin
      if (cmd.mul_a) mst[j] <= fp_mul_a(lop, rmat[cmd.k][j]);
      if (cmd.mul_b) prod[j] <= fp_mul_b(mst[j]);
      if (cmd.add_a) ast[j] <= fp_add_a(acc[j], prod[j]);
      if (cmd.add_b) acc[j] <= cmd.first_k ? prod[j] : fp_add_b(ast[j]);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata[1:0] <= cmd.i;
      for (int j = 0; j < DIM; j++) begin
        m_tdata[2 + j*FP_W +: FP_W] <= acc[j];
      end
      m_tdata[OUT_W-1:2 + DIM*FP_W] <= '0;
      m_tlast <= (cmd.i == 2'(DIM - 1));
    end
  end

endmodule

@@ hw/rtl/matrix4x4_float_multiply_unit.sv @@
// ----------------------------------------------------------------------------
// matrix4x4_float_multiply_unit
// 4x4 binary32 matrix product, one row pair per input, four rows out.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)               | tlast
//  s_*     | in  | row_index, left_e0..3, right_e0..3, pad  | compute_now
//  m_*     | out | out_row, prod_e0..3, pad                 | last_row
//
//  A row item is stored when it is taken. A compute item then runs, for
//  each of 4 rows, every k term through two multiply steps and two add
//  steps on four lanes, then loads the output register; input is not
//  taken again until the last row is loaded. Rows leave while later rows
//  compute; a stalled output holds the sequencer in its emit step. Reset
//  clears both stores to +0 and the handshake state.
// ----------------------------------------------------------------------------
module matrix4x4_float_multiply_unit import m44_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // row_index, left_e0..3, right_e0..3
  input  logic             s_tlast,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,  // out_row, prod_e0..3
  output logic             m_tlast
);

  m44_cmd_t cmd;

  m44_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  m44_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule

@@ hw/rtl/m44_checker.sv @@
// ----------------------------------------------------------------------------
// m44_checker
// Port-level checks for the matrix multiply unit, bound to the top level.
// ----------------------------------------------------------------------------
module m44_checker import m44_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             s_tlast,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  // Stop taking input once a compute starts
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken during compute");

  // Final row carries the last row index
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[1:0] == 2'(DIM - 1))
    else $error("last flag on wrong row");

  // Earlier rows only appear while the compute is still running
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input open before all rows sent");

endmodule

bind matrix4x4_float_multiply_unit m44_checker u_m44_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

@@ test/tb_matrix4x4_float_multiply_unit.sv @@
// ----------------------------------------------------------------------------
// tb_matrix4x4_float_multiply_unit
// Stream-level test of the 4x4 binary32 matrix multiply unit. Row pairs are
// sent with random content and gaps; a scoreboard keeps its own copy of both
// operand stores, predicts every product row with per-operation
// round-to-nearest-even and checks each output transfer field by field.
// ----------------------------------------------------------------------------
module tb_matrix4x4_float_multiply_unit;
  import m44_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_STALL     = 400;

  // One predicted product row
  typedef struct {
    logic [1:0]  row;
    logic [31:0] elem [DIM];
    logic        last;
  } prod_row_t;

  // --------------------------------------------------------------------------
  // Scoreboard: operand stores, product prediction, output checking
  // --------------------------------------------------------------------------
  class matmul_scoreboard;
    logic [31:0] left_mat  [DIM*DIM];
    logic [31:0] right_mat [DIM*DIM];
    prod_row_t   pending_rows [$];
    int          errors;

    function new();
      foreach (left_mat[n]) begin
        left_mat[n]  = '0;
        right_mat[n] = '0;
      end
      errors = 0;
    endfunction

    // Widen a binary32 pattern to a real, exactly
    function real fp_to_real(logic [31:0] b);
      real v;
      if (b[30:23] == 8'hFF) begin
        if (b[22:0] != 23'd0) return $bitstoreal(64'h7FF8_0000_0000_0000);
        return $bitstoreal({b[31], 11'h7FF, 52'b0});
      end
      if (b[30:23] == 8'd0) begin
        if (b[22:0] == 23'd0) return $bitstoreal({b[31], 63'b0});
        // subnormal: mantissa times 2^-149
        v = real'(b[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
        return b[31] ? -v : v;
      end
      return $bitstoreal({b[31], 11'(b[30:23]) + 11'd896, b[22:0], 29'b0});
    endfunction

    // Round a real to binary32, nearest even, keeping subnormals
    function logic [31:0] real_to_fp(real v);
      logic [63:0] d;
      logic [63:0] sig;
      logic [63:0] kept;
      logic        sgn;
      logic        half;
      logic        sticky;
      int          fe;
      int          sh;
      d   = $realtobits(v);
      sgn = d[63];
      if (d[62:52] == 11'h7FF) begin
        if (d[51:0] != 52'd0) return CANON_NAN;
        return {sgn, 8'hFF, 23'b0};
      end
      if (d[62:52] == 11'd0) return {sgn, 31'b0};
      fe  = int'(d[62:52]) - 1023 + 127;
      sig = {11'b0, 1'b1, d[51:0]};
      sh  = (fe >= 1) ? 29 : 29 + 1 - fe;
      if (sh > 60) return {sgn, 31'b0};
      kept   = sig >> sh;
      half   = sig[sh-1];
      sticky = (sig & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
      if (half && (sticky || kept[0])) kept = kept + 64'd1;
      if (fe < 1) return {sgn, kept[30:0]};
      if (kept[24]) begin
        kept = kept >> 1;
        fe   = fe + 1;
      end
      if (fe >= 255) return {sgn, 8'hFF, 23'b0};
      return {sgn, 8'(fe), kept[22:0]};
    endfunction

    function logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
      return real_to_fp(fp_to_real(a) * fp_to_real(b));
    endfunction

    function logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
      return real_to_fp(fp_to_real(a) + fp_to_real(b));
    endfunction

    // Store an accepted row pair; on compute, queue the four product rows
    function void note_row(logic [1:0] ri, logic [31:0] l [DIM],
                           logic [31:0] r [DIM], logic compute);
      prod_row_t   pr;
      logic [31:0] acc;
      for (int c = 0; c < DIM; c++) begin
        left_mat[ri*DIM + c]  = l[c];
        right_mat[ri*DIM + c] = r[c];
      end
      if (!compute) return;
      for (int i = 0; i < DIM; i++) begin
        pr.row  = 2'(i);
        pr.last = (i == DIM - 1);
        for (int j = 0; j < DIM; j++) begin
          acc = fp_mul(left_mat[i*DIM], right_mat[j]);
          for (int k = 1; k < DIM; k++)
            acc = fp_add(acc, fp_mul(left_mat[i*DIM + k], right_mat[k*DIM + j]));
          pr.elem[j] = acc;
        end
        pending_rows.push_back(pr);
      end
    endfunction

    // Compare one output transfer with the oldest predicted row
    function void check_row(logic [OUT_W-1:0] data, logic last);
      prod_row_t pr;
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected output row, data %h last %b", $time, data, last);
        errors++;
        return;
      end
      pr = pending_rows.pop_front();
      if (data[1:0] !== pr.row) begin
        $display("%0t: out_row expected %0d actual %0d", $time, pr.row, data[1:0]);
        errors++;
      end
      for (int j = 0; j < DIM; j++) begin
        if (data[2 + 32*j +: 32] !== pr.elem[j]) begin
          $display("%0t: row %0d prod_e%0d expected %h actual %h", $time, pr.row, j,
                   pr.elem[j], data[2 + 32*j +: 32]);
          errors++;
        end
      end
      if (last !== pr.last) begin
        $display("%0t: row %0d last_row expected %b actual %b", $time, pr.row,
                 pr.last, last);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             s_tlast = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;

  matmul_scoreboard sb;
  bit               hold_output = 1'b0;
  int               idle_cycles = 0;

  matrix4x4_float_multiply_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Gap length: mostly short, a few long
  function automatic int pick_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 0;
      4, 5, 6:    return $urandom_range(1, 3);
      7, 8:       return $urandom_range(4, 10);
      default:    return $urandom_range(20, 40);
    endcase
  endfunction

  // Operand value with a bias toward interesting classes
  function automatic logic [31:0] pick_fp();
    logic s;
    s = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 11))
      0, 1, 2, 3: return {s, 8'($urandom_range(118, 136)), 23'($urandom)};
      4, 5:       return $urandom;
      6:          return {s, 8'd0, 23'($urandom)};
      7:          return {s, 8'($urandom_range(200, 254)), 23'($urandom)};
      8:          return {s, 8'($urandom_range(1, 40)), 23'($urandom)};
      9:          return {s, 31'b0};
      10:         return {s, 8'hFF, 23'b0};
      default: begin
        case ($urandom_range(0, 3))
          0:       return {s, 8'hFF, 23'($urandom) | 23'd1};
          1:       return {s, 8'hFE, 23'h7FFFFF};
          2:       return {s, 31'd1};
          default: return {s, 8'd127, 23'b0};
        endcase
      end
    endcase
  endfunction

  // Offer one row pair and hold it until the transfer
  task automatic send_row(logic [1:0] ri, logic [31:0] l [DIM], logic [31:0] r [DIM],
                          logic compute, bit with_gap = 1'b1);
    int gap;
    s_tdata  <= {6'b0, r[3], r[2], r[1], r[0], l[3], l[2], l[1], l[0], ri};
    s_tlast  <= compute;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_row(ri, l, r, compute);
    gap = with_gap ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_row(logic [1:0] ri, logic compute, bit with_gap = 1'b1);
    logic [31:0] l [DIM];
    logic [31:0] r [DIM];
    foreach (l[c]) begin
      l[c] = pick_fp();
      r[c] = pick_fp();
    end
    send_row(ri, l, r, compute, with_gap);
  endtask

  // Load all four rows in a shuffled order, compute on the last one
  task automatic send_matrix(bit with_gap = 1'b1);
    int order [DIM];
    int a;
    int t;
    foreach (order[n]) order[n] = n;
    for (int n = DIM - 1; n > 0; n--) begin
      a = $urandom_range(0, n);
      t = order[n];
      order[n] = order[a];
      order[a] = t;
    end
    foreach (order[n]) send_random_row(2'(order[n]), n == DIM - 1, with_gap);
  endtask

  // Drop the offer and wait until every predicted row has left
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending_rows.size() != 0) @(posedge clk);
  endtask

  // Output side: random ready, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_row(m_tdata, m_tlast);
      if (hold_output) begin
        m_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        hold_output = 1'b0;
      end
      m_tready <= (pick_gap() == 0);
    end
  end

  // Watchdog: count cycles with no transfer on either side
  initial begin
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] l [DIM];
    logic [31:0] r [DIM];
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Compute straight after reset: untouched rows read as +0
    l = '{32'h3F80_0000, 32'h4000_0000, 32'hC040_0000, 32'h4080_0000};
    r = '{32'h3F80_0000, 32'h3F00_0000, 32'h4120_0000, 32'hBF80_0000};
    send_row(2'd2, l, r, 1'b1);
    wait_drained();

    // Extremes and special values, one row at a time
    l = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000};
    r = '{32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001};
    send_row(2'd0, l, r, 1'b0);
    l = '{32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h007F_FFFF, 32'h0080_0000};
    r = '{32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h3F00_0000, 32'h0080_0000};
    send_row(2'd1, l, r, 1'b0);
    l = '{32'h3F80_0001, 32'hBF80_0000, 32'h3380_0000, 32'h7FFF_FFFF};
    r = '{32'h3F80_0000, 32'h3F80_0001, 32'h3F80_0000, 32'h0000_0000};
    send_row(2'd2, l, r, 1'b0);
    l = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hAAAA_AAAA, 32'h5555_5555};
    r = '{32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'h0000_0000};
    send_row(2'd3, l, r, 1'b1);
    // Reload one row and compute again: other rows keep their contents
    l = '{32'h7F80_0000, 32'h7F80_0000, 32'h0000_0000, 32'h3F80_0000};
    r = '{32'hFF80_0000, 32'h7F80_0000, 32'h7F80_0000, 32'h8000_0000};
    send_row(2'd1, l, r, 1'b0);
    send_row(2'd1, r, l, 1'b1);
    // Compute on each row index
    for (int n = 0; n < DIM; n++) send_random_row(2'(n), 1'b1);
    wait_drained();

    // Back-pressure: hold the output while computes keep arriving
    hold_output = 1'b1;
    repeat (3) send_matrix(1'b0);
    wait_drained();

    // Random part: mostly complete matrices, some partial loads
    for (int n = 0; n < 85; n++) begin
      if ($urandom_range(0, 4) != 0) send_matrix();
      else send_random_row(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      if (n == 40) wait_drained();
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending_rows.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
